>>> design/lli_pkg.sv
// Shared types and widths for the line intersection core.
package lli_pkg;
   localparam int CoordW = 32;
   localparam int NumMagW = 97;
   localparam int DenMagW = 66;

   typedef struct packed {
      logic [DenMagW-1:0] den_mag;
      logic [NumMagW-1:0] rem_x;
      logic [NumMagW-1:0] rem_y;
      logic [CoordW-1:0]  q_x;
      logic [CoordW-1:0]  q_y;
      logic               neg_x;
      logic               neg_y;
      logic               big_x;
      logic               big_y;
      logic               par;
   } div_type;
endpackage

>>> design/lli_front.sv
// Cross products, shared denominator and wide numerators ahead of the divider chain.
module lli_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [31:0]    x1,
   input  logic signed [31:0]    y1,
   input  logic signed [31:0]    x2,
   input  logic signed [31:0]    y2,
   input  logic signed [31:0]    x3,
   input  logic signed [31:0]    y3,
   input  logic signed [31:0]    x4,
   input  logic signed [31:0]    y4,
   output logic                  out_valid,
   output lli_pkg::div_type      out_div
);
   import lli_pkg::*;

   logic [5:0] v_ff;

   logic signed [63:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [32:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic signed [32:0] dx1_in, dy1_in, dx2_in, dy2_in;

   logic signed [64:0] c1_ff, c2_ff;
   logic signed [65:0] q1_ff, q2_ff;
   logic signed [32:0] dx1b_ff, dy1b_ff, dx2b_ff, dy2b_ff;

   logic signed [66:0] den_ff, den2_ff, den3_ff;
   logic signed [32:0] c1h, c1l, c2h, c2l;
   logic signed [65:0] m_ff [8];

   logic signed [97:0] t_in [4];
   logic signed [97:0] t_ff [4];

   logic signed [97:0] nx_ff, ny_ff;

   logic [NumMagW-1:0] mx_in, my_in;
   logic [DenMagW-1:0] dm_in;
   div_type            d_ff;

   assign dx1_in = 33'(x1) - 33'(x2);
   assign dy1_in = 33'(y1) - 33'(y2);
   assign dx2_in = 33'(x3) - 33'(x4);
   assign dy2_in = 33'(y3) - 33'(y4);

   assign c1h = c1_ff[64:32];
   assign c1l = {1'b0, c1_ff[31:0]};
   assign c2h = c2_ff[64:32];
   assign c2l = {1'b0, c2_ff[31:0]};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         t_in[i] = $signed({m_ff[2*i], 32'b0}) + $signed({{32{m_ff[2*i+1][65]}}, m_ff[2*i+1]});
      end
      mx_in = nx_ff[97] ? NumMagW'(-nx_ff) : NumMagW'(nx_ff);
      my_in = ny_ff[97] ? NumMagW'(-ny_ff) : NumMagW'(ny_ff);
      dm_in = den3_ff[66] ? DenMagW'(-den3_ff) : DenMagW'(den3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
      if (en) begin
         pa_ff  <= x1 * y2;
         pb_ff  <= y1 * x2;
         pc_ff  <= x3 * y4;
         pd_ff  <= y3 * x4;
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;

         c1_ff   <= 65'(pa_ff) - 65'(pb_ff);
         c2_ff   <= 65'(pc_ff) - 65'(pd_ff);
         q1_ff   <= dx1_ff * dy2_ff;
         q2_ff   <= dy1_ff * dx2_ff;
         dx1b_ff <= dx1_ff;
         dy1b_ff <= dy1_ff;
         dx2b_ff <= dx2_ff;
         dy2b_ff <= dy2_ff;

         den_ff  <= 67'(q1_ff) - 67'(q2_ff);
         m_ff[0] <= c1h * dx2b_ff;
         m_ff[1] <= c1l * dx2b_ff;
         m_ff[2] <= c2h * dx1b_ff;
         m_ff[3] <= c2l * dx1b_ff;
         m_ff[4] <= c1h * dy2b_ff;
         m_ff[5] <= c1l * dy2b_ff;
         m_ff[6] <= c2h * dy1b_ff;
         m_ff[7] <= c2l * dy1b_ff;

         den2_ff <= den_ff;
         for (int i = 0; i < 4; i++) begin
            t_ff[i] <= t_in[i];
         end

         den3_ff <= den2_ff;
         nx_ff   <= t_ff[0] - t_ff[1];
         ny_ff   <= t_ff[2] - t_ff[3];

         d_ff.den_mag <= dm_in;
         d_ff.rem_x   <= mx_in;
         d_ff.rem_y   <= my_in;
         d_ff.q_x     <= '0;
         d_ff.q_y     <= '0;
         d_ff.neg_x   <= nx_ff[97] != den3_ff[66];
         d_ff.neg_y   <= ny_ff[97] != den3_ff[66];
         d_ff.big_x   <= mx_in >= {dm_in[NumMagW-33:0], 32'b0} && !dm_in[DenMagW-1];
         d_ff.big_y   <= my_in >= {dm_in[NumMagW-33:0], 32'b0} && !dm_in[DenMagW-1];
         d_ff.par     <= den3_ff == '0;
      end
   end

   assign out_valid = v_ff[5];
   assign out_div   = d_ff;
endmodule

>>> design/lli_div_cell.sv
// One restoring-division cell that settles one quotient bit for both coordinates.
module lli_div_cell #(
   parameter int K = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  lli_pkg::div_type in_div,
   output logic             out_valid,
   output lli_pkg::div_type out_div
);
   import lli_pkg::*;

   localparam int Shift = CoordW - 1 - K;

   logic [NumMagW-1:0] dsh;
   div_type            div_in;
   div_type            div_ff;
   logic               valid_ff;

   always_comb begin
      dsh    = NumMagW'(in_div.den_mag) << Shift;
      div_in = in_div;
      if (in_div.rem_x >= dsh) begin
         div_in.rem_x     = in_div.rem_x - dsh;
         div_in.q_x[Shift] = 1'b1;
      end
      if (in_div.rem_y >= dsh) begin
         div_in.rem_y     = in_div.rem_y - dsh;
         div_in.q_y[Shift] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
endmodule

>>> design/line_line_intersection_core.sv
// Top level of the two-line intersection core: front end, divider chain and output register.
// One pair of lines is taken every cycle unless the core stalls; each pair passes through
// six arithmetic stages, a row of 32 divider cells (one quotient bit each) and the
// output register. The whole pipeline holds while a result is stalled.
module line_line_intersection_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_first_begin_x,
   input  logic signed [31:0] req_first_begin_y,
   input  logic signed [31:0] req_first_end_x,
   input  logic signed [31:0] req_first_end_y,
   input  logic signed [31:0] req_second_begin_x,
   input  logic signed [31:0] req_second_begin_y,
   input  logic signed [31:0] req_second_end_x,
   input  logic signed [31:0] req_second_end_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_cross_x,
   output logic signed [31:0] rsp_cross_y,
   output logic               rsp_parallel,
   output logic               rsp_overflow
);
   import lli_pkg::*;

   logic    en;
   logic    v [33];
   div_type d [33];

   logic        rsp_valid_ff;
   logic [31:0] cx_ff, cy_ff, cx_in, cy_in;
   logic        par_ff, ovf_ff, ovf_in, ox, oy;

   assign en = !rsp_valid_ff || !rsp_stall;

   lli_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .x1(req_first_begin_x), .y1(req_first_begin_y),
      .x2(req_first_end_x), .y2(req_first_end_y),
      .x3(req_second_begin_x), .y3(req_second_begin_y),
      .x4(req_second_end_x), .y4(req_second_end_y),
      .out_valid(v[0]), .out_div(d[0])
   );

   for (genvar k = 0; k < 32; k++) begin : g_cell
      lli_div_cell #(.K(k)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(v[k]), .in_div(d[k]),
         .out_valid(v[k+1]), .out_div(d[k+1])
      );
   end

   function automatic logic [32:0] sat(input logic big, input logic neg, input logic [31:0] q);
      logic [32:0] mag;
      logic [32:0] r;
      mag = big ? 33'h1_0000_0000 : {1'b0, q};
      r   = {1'b0, neg ? 32'(-mag) : mag[31:0]};
      if (!neg && mag > 33'h0_7FFF_FFFF) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (neg && mag > 33'h0_8000_0000) begin
         r = {1'b1, 32'h8000_0000};
      end
      return r;
   endfunction

   always_comb begin
      {ox, cx_in} = sat(d[32].big_x, d[32].neg_x, d[32].q_x);
      {oy, cy_in} = sat(d[32].big_y, d[32].neg_y, d[32].q_y);
      ovf_in = ox || oy;
      if (d[32].par) begin
         cx_in  = '0;
         cy_in  = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v[32];
      end
      if (en) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         par_ff <= d[32].par;
         ovf_ff <= ovf_in;
      end
   end

   assign req_stall    = !en;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cross_x  = cx_ff;
   assign rsp_cross_y  = cy_ff;
   assign rsp_parallel = par_ff;
   assign rsp_overflow = ovf_ff;
endmodule

>>> design/lli_checker.sv
// Port-level checks for the line intersection core and their binding.
module lli_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_cross_x,
   input logic [31:0] rsp_cross_y,
   input logic        rsp_parallel,
   input logic        rsp_overflow
);
   a_par_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parallel |-> rsp_cross_x == '0 && rsp_cross_y == '0 && !rsp_overflow)
      else $error("parallel item carries coordinates or overflow");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_cross_x == 32'h7FFF_FFFF || rsp_cross_x == 32'h8000_0000
         || rsp_cross_y == 32'h7FFF_FFFF || rsp_cross_y == 32'h8000_0000)
      else $error("overflow without a saturated coordinate");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cross_x) && $stable(rsp_cross_y))
      else $error("stalled result item changed");
endmodule

bind line_line_intersection_core lli_checker u_lli_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y),
   .rsp_parallel(rsp_parallel), .rsp_overflow(rsp_overflow)
);
